### src/int_long_alu_core_defines.svh
// assertion macros for the int_long_alu_core checker
// needs clock and reset in the scope where the macros are used
`ifndef INT_LONG_ALU_CORE_DEFINES_SVH
`define INT_LONG_ALU_CORE_DEFINES_SVH

// same-cycle implication
`define ILALU_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ILALU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/ilalu_pkg.sv
// shared types, operation codes and helpers of the integer/long alu
// no dependencies
package ilalu_pkg;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;
   localparam logic [2:0] CMD_REM = 3'd4;
   localparam logic [2:0] CMD_NEG = 3'd5;
   localparam logic [2:0] CMD_SHL = 3'd6;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        wide;
      logic [63:0] a;
      logic [63:0] b;
      logic [5:0]  shamt;
      logic        dz;
   } op_type;

   function automatic logic [63:0] sext32(input logic [63:0] v);
      sext32 = {{32{v[31]}}, v[31:0]};
   endfunction

   function automatic logic [63:0] fit(input logic [63:0] v, input logic wide);
      fit = wide ? v : sext32(v);
   endfunction

endpackage

### src/ilalu_front.sv
// front end: normalizes operands to 64 bits and classifies the operation
// depends on ilalu_pkg
module ilalu_front (
   input  logic [2:0]      cmd,
   input  logic            wide,
   input  logic [63:0]     operand_a,
   input  logic [63:0]     operand_b,
   output ilalu_pkg::op_type op
);
   import ilalu_pkg::*;

   logic [63:0] a_ext;
   logic [63:0] b_ext;

   assign a_ext = fit(operand_a, wide);
   assign b_ext = fit(operand_b, wide);

   always_comb begin
      op.cmd   = cmd;
      op.wide  = wide;
      op.a     = a_ext;
      op.b     = b_ext;
      // int shifts use only five count bits
      op.shamt = wide ? b_ext[5:0] : {1'b0, b_ext[4:0]};
      op.dz    = ((cmd == CMD_DIV) || (cmd == CMD_REM)) && (b_ext == 64'd0);
   end
endmodule

### src/ilalu_queue.sv
// two-entry queue between the front end and the execution back end
// depends on ilalu_pkg
module ilalu_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ilalu_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output ilalu_pkg::op_type head_op
);
   import ilalu_pkg::*;

   op_type     slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_op    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end
endmodule

### src/ilalu_back.sv
// back end: simple ops, partial-product multiply, bit-serial divide, output register
// depends on ilalu_pkg
module ilalu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  ilalu_pkg::op_type head_op,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [63:0]      rsp_result,
   output logic             rsp_div_by_zero
);
   import ilalu_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DFIN = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic        valid_ff, valid_in;
   logic [63:0] res_ff, res_in;
   logic        dz_ff, dz_in;
   logic        wide_ff, wide_in;
   logic        is_rem_ff, is_rem_in;
   logic        neg_q_ff, neg_q_in;
   logic        neg_r_ff, neg_r_in;
   logic [63:0] p0_ff, p0_in;
   logic [31:0] p1_ff, p1_in;
   logic [31:0] p2_ff, p2_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] mb_ff, mb_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic        out_free;
   logic [63:0] simple_res;
   logic [63:0] mag_a;
   logic [63:0] mag_b;
   logic [64:0] diff;
   logic [63:0] mul_sum;
   logic [63:0] div_res;

   assign out_free = !valid_ff || !rsp_stall;
   assign mag_a    = head_op.a[63] ? 64'd0 - head_op.a : head_op.a;
   assign mag_b    = head_op.b[63] ? 64'd0 - head_op.b : head_op.b;
   assign diff     = {rem_ff, quo_ff[63]} - {1'b0, mb_ff};
   assign mul_sum  = p0_ff + {p1_ff + p2_ff, 32'd0};
   assign div_res  = is_rem_ff ? (neg_r_ff ? 64'd0 - rem_ff : rem_ff)
                               : (neg_q_ff ? 64'd0 - quo_ff : quo_ff);

   always_comb begin
      unique case (head_op.cmd)
         CMD_ADD: simple_res = head_op.a + head_op.b;
         CMD_SUB: simple_res = head_op.a - head_op.b;
         CMD_NEG: simple_res = 64'd0 - head_op.a;
         CMD_SHL: simple_res = head_op.a << head_op.shamt;
         default: simple_res = 64'd0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      res_in    = res_ff;
      dz_in     = dz_ff;
      wide_in   = wide_ff;
      is_rem_in = is_rem_ff;
      neg_q_in  = neg_q_ff;
      neg_r_in  = neg_r_ff;
      p0_in     = p0_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      mb_in     = mb_ff;
      cnt_in    = cnt_ff;
      pop       = 1'b0;
      valid_in  = valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               wide_in = head_op.wide;
               if (!head_op.dz && head_op.cmd == CMD_MUL) begin
                  pop   = 1'b1;
                  p0_in = {32'd0, head_op.a[31:0]} * {32'd0, head_op.b[31:0]};
                  p1_in = head_op.a[31:0] * head_op.b[63:32];
                  p2_in = head_op.a[63:32] * head_op.b[31:0];
                  state_in = ST_MUL;
               end else if (!head_op.dz &&
                            (head_op.cmd == CMD_DIV || head_op.cmd == CMD_REM)) begin
                  pop       = 1'b1;
                  is_rem_in = (head_op.cmd == CMD_REM);
                  neg_q_in  = head_op.a[63] ^ head_op.b[63];
                  neg_r_in  = head_op.a[63];
                  rem_in    = 64'd0;
                  quo_in    = mag_a;
                  mb_in     = mag_b;
                  cnt_in    = 6'd0;
                  state_in  = ST_DIV;
               end else if (out_free) begin
                  // simple ops and zero-divisor transfers
                  pop      = 1'b1;
                  valid_in = 1'b1;
                  res_in   = fit(simple_res, head_op.wide);
                  dz_in    = head_op.dz;
               end
            end
         end
         ST_MUL: begin
            if (out_free) begin
               valid_in = 1'b1;
               res_in   = fit(mul_sum, wide_ff);
               dz_in    = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle, restoring
            if (!diff[64]) begin
               rem_in = diff[63:0];
            end else begin
               rem_in = {rem_ff[62:0], quo_ff[63]};
            end
            quo_in = {quo_ff[62:0], !diff[64]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_DFIN;
            end
         end
         default: begin
            if (out_free) begin
               valid_in = 1'b1;
               res_in   = fit(div_res, wide_ff);
               dz_in    = 1'b0;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff    <= res_in;
      dz_ff     <= dz_in;
      wide_ff   <= wide_in;
      is_rem_ff <= is_rem_in;
      neg_q_ff  <= neg_q_in;
      neg_r_ff  <= neg_r_in;
      p0_ff     <= p0_in;
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      mb_ff     <= mb_in;
      cnt_ff    <= cnt_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result      = res_ff;
   assign rsp_div_by_zero = dz_ff;
endmodule

### src/int_long_alu_core.sv
// Integer/long ALU: add, sub, neg and shift left stream one per cycle while the
// response side does not stall; multiply holds the execution stage to form
// three 32x32 partial products, then one sum; div and rem run a restoring divider
// at one quotient bit per cycle in the execution stage. A two-entry queue
// lets the request side keep transferring while the back end is busy, and an
// output register holds a result while the response side stalls. Results leave
// in request order; a zero divisor returns 0 with div_by_zero set.
// depends on ilalu_pkg, ilalu_front, ilalu_queue, ilalu_back
module int_long_alu_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic               req_wide,
   input  logic signed [63:0] req_operand_a,
   input  logic signed [63:0] req_operand_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_result,
   output logic               rsp_div_by_zero
);
   import ilalu_pkg::*;

   op_type      front_op;
   op_type      head_op;
   logic        q_full;
   logic        head_valid;
   logic        pop;
   logic [63:0] result_bits;

   ilalu_front u_front (
      .cmd       (req_cmd),
      .wide      (req_wide),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .op        (front_op)
   );

   ilalu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && !q_full),
      .push_op    (front_op),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   ilalu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_op         (head_op),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (result_bits),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

   assign req_stall  = q_full;
   assign rsp_result = result_bits;
endmodule

### src/ilalu_checker.sv
// port-level checks for int_long_alu_core, bound to the top level
// depends on int_long_alu_core_defines.svh
`include "int_long_alu_core_defines.svh"

module ilalu_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [63:0] rsp_result,
   input logic               rsp_div_by_zero
);
   `ILALU_ASSERT(a_dz_zero, rsp_valid && rsp_div_by_zero, rsp_result == 64'sd0, "dz result nonzero")
   `ILALU_ASSERT(a_reset_quiet, $past(reset), !rsp_valid, "response right after reset")
   `ILALU_ASSERT_NEXT(a_hold_valid, rsp_valid && rsp_stall, rsp_valid, "stalled response dropped")
   `ILALU_ASSERT_NEXT(a_hold_data, rsp_valid && rsp_stall, $stable(rsp_result), "stalled result changed")
endmodule

bind int_long_alu_core ilalu_checker u_ilalu_checker (.*);
